### src/pshtn_pkg.sv
// Package for the sampling profiler histogram: item structs, opcodes,
// configuration indexes, controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pshtn_pkg;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 5;
    localparam int unsigned DEFAULT_TOP = 10;
    localparam int unsigned PCT_SCALE   = 100;
    localparam logic [4:0]  GSHIFT_RST  = 5'd4;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_DUMP   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 1'b0,
        CFG_GSHIFT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] pc_value;
        logic [7:0]  report_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] total_samples;
        logic [6:0]  rank;
        logic [31:0] bucket_base;
        logic [31:0] hit_count;
        logic [6:0]  percent;
        logic        entry_valid;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SWR,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DIV,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic accept;
        logic dump_init;
        logic clear;
        logic mod_step;
        logic smp_rd;
        logic smp_wr;
        logic scan_rd;
        logic scan_init;
        logic mul;
        logic div_step;
        logic load_entry;
        logic load_empty;
        logic mark;
    } t_cmd;

    typedef struct packed {
        logic enable;
        logic total_zero;
        logic mod_done;
        logic scan_last;
        logic best_zero;
        logic div_done;
        logic last_entry;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### src/pshtn_ctrl.sv
// Controller of the histogram: sequences samples, clears and dumps.
// Depends on pshtn_pkg; drives the datapath through t_cmd, reads t_status.
`timescale 1ns / 1ps
`default_nettype none

module pshtn_ctrl
    import pshtn_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic [1:0] i_opcode,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_opcode)
                        OP_SAMPLE: begin
                            if (i_status.enable) begin
                                n_state = ST_MOD;
                            end
                        end
                        OP_DUMP: begin
                            o_cmd.dump_init = 1'b1;
                            o_cmd.scan_init = 1'b1;
                            n_state = i_status.total_zero ? ST_EMPTY : ST_SCAN;
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (i_status.mod_done) begin
                    o_cmd.smp_rd = 1'b1;
                    n_state = ST_SWR;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            ST_SWR: begin
                o_cmd.smp_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // nothing left to report on the first pass: empty result
                if (i_status.best_zero) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_entry = 1'b1;
                    if (i_status.last_entry) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.mark      = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/pshtn_dpath.sv
// Datapath of the histogram: bucket memories, remainder unit, top-entry scan,
// percent divider, configuration registers and the result register.
// Depends on pshtn_pkg; controlled through t_cmd, reports t_status.
`timescale 1ns / 1ps
`default_nettype none

module pshtn_dpath
    import pshtn_pkg::*;
#(
    parameter int unsigned BUCKETS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item
);

    localparam int unsigned    IDX_W    = $clog2(BUCKETS);
    localparam bit             IS_POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);
    localparam logic [IDX_W:0] BKT_W1   = (IDX_W + 1)'(BUCKETS);
    localparam logic [7:0]     BKT_8    = 8'(BUCKETS);
    localparam int unsigned    RCP_SH   = 32 + IDX_W;
    localparam logic [32:0]    RCP      =
        33'(((65'd1 << RCP_SH) + 65'(BUCKETS - 1)) / 65'(BUCKETS));

    // configuration
    logic       r_enable;
    logic [4:0] r_gshift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_gshift <= GSHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_GSHIFT: r_gshift <= i_cfg_data[4:0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // bucket index: mask for a power-of-two count, else a reciprocal product
    // gives the quotient and the remainder follows from low bits
    logic [31:0]      r_mod_word;
    logic [31:0]      r_quot;
    logic             r_quot_vld;
    logic [31:0]      r_base;
    logic [64:0]      w_prod;
    logic [IDX_W-1:0] w_qm;
    logic [IDX_W-1:0] w_idx;

    assign w_prod = {33'd0, r_mod_word} * {32'd0, RCP};
    assign w_qm   = IDX_W'(r_quot[IDX_W-1:0] * BKT_W1);
    assign w_idx  = IS_POW2 ? r_mod_word[IDX_W-1:0] : r_mod_word[IDX_W-1:0] - w_qm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mod_word <= i_in_item.pc_value >> r_gshift;
            r_quot_vld <= 1'b0;
            r_base     <= i_in_item.pc_value & ~((32'h1 << r_gshift) - 32'h1);
        end else if (i_cmd.mod_step) begin
            r_quot     <= 32'(w_prod >> RCP_SH);
            r_quot_vld <= 1'b1;
        end
    end

    // bucket stores; a bucket that is not valid reads as zero
    logic [31:0]        mem_hits  [BUCKETS];
    logic [31:0]        mem_bases [BUCKETS];
    logic [BUCKETS-1:0] r_valid;
    logic [BUCKETS-1:0] r_marks;
    logic [31:0]        r_hit_rd;
    logic               r_vld_rd;
    logic [31:0]        r_base_rd;
    logic [31:0]        r_total;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [31:0]        w_hits_eff;

    // scan state, declared ahead of the memory read that uses it
    logic [IDX_W-1:0] r_scan;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_best;
    logic [31:0]      r_best_hits;
    logic [1:0]       r_ncand;
    logic             w_cand;

    assign w_rd_addr  = i_cmd.scan_rd ? r_scan : w_idx;
    assign w_hits_eff = r_vld_rd ? r_hit_rd : 32'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_rd || i_cmd.scan_rd) begin
            r_hit_rd <= mem_hits[w_rd_addr];
            r_vld_rd <= r_valid[w_rd_addr];
        end
        if (i_cmd.mul) begin
            r_base_rd <= mem_bases[r_best];
        end
        if (i_cmd.smp_wr) begin
            mem_hits[w_idx] <= w_hits_eff + 32'd1;
            if (w_hits_eff == 32'd0) begin
                mem_bases[w_idx] <= r_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_cmd.smp_wr) begin
            r_valid[w_idx] <= 1'b1;
            r_total        <= r_total + 32'd1;
        end
    end

    // scan: one bucket a cycle, each compared in the cycle after its read
    assign w_cand = r_cmp_vld && !r_marks[r_cmp_idx] && (w_hits_eff != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_marks   <= '0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.dump_init) begin
                r_marks <= '0;
            end else if (i_cmd.mark) begin
                r_marks[r_best] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan;
        if (i_cmd.scan_init) begin
            r_scan      <= '0;
            r_best      <= '0;
            r_best_hits <= '0;
            r_ncand     <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_scan <= r_scan + IDX_W'(1);
            end
            if (w_cand) begin
                // strict compare keeps the lowest index on a tie
                if (w_hits_eff > r_best_hits) begin
                    r_best_hits <= w_hits_eff;
                    r_best      <= r_cmp_idx;
                end
                if (r_ncand != 2'd2) begin
                    r_ncand <= r_ncand + 2'd1;
                end
            end
        end
    end

    // entries wanted and next rank
    logic [7:0] w_want;
    logic [6:0] r_want;
    logic [6:0] r_rank;

    always_comb begin
        w_want = i_in_item.report_count;
        if (w_want == 8'd0 || w_want > BKT_8) begin
            w_want = 8'(DEFAULT_TOP);
        end
        if (w_want > BKT_8) begin
            w_want = BKT_8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_init) begin
            r_want <= w_want[6:0];
            r_rank <= 7'd1;
        end else if (i_cmd.mark) begin
            r_rank <= r_rank + 7'd1;
        end
    end

    // percent: product by 100, then restoring division one quotient bit a cycle;
    // the first step only flags a quotient too large for eight bits
    logic [39:0] r_rem;
    logic [7:0]  r_q;
    logic        r_sat;
    logic [3:0]  r_k;
    logic [39:0] w_div;
    logic [6:0]  w_pct;

    assign w_div = {8'd0, r_total} << r_k;
    assign w_pct = (r_sat || r_q > 8'(PCT_SCALE)) ? 7'(PCT_SCALE) : r_q[6:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem <= 40'(r_best_hits) * 40'(PCT_SCALE);
            r_q   <= '0;
            r_sat <= 1'b0;
            r_k   <= 4'd8;
        end else if (i_cmd.div_step) begin
            if (r_rem >= w_div) begin
                if (r_k == 4'd8) begin
                    r_sat <= 1'b1;
                end else begin
                    r_rem           <= r_rem - w_div;
                    r_q[r_k[2:0]]   <= 1'b1;
                end
            end
            r_k <= r_k - 4'd1;
        end
    end

    // result register
    logic      r_out_vld;
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_entry || i_cmd.load_empty) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry) begin
            r_out_item.total_samples <= r_total;
            r_out_item.rank          <= r_rank;
            r_out_item.bucket_base   <= r_base_rd;
            r_out_item.hit_count     <= r_best_hits;
            r_out_item.percent       <= w_pct;
            r_out_item.entry_valid   <= 1'b1;
            r_out_item.last          <= o_status.last_entry;
        end else if (i_cmd.load_empty) begin
            r_out_item.total_samples <= r_total;
            r_out_item.rank          <= '0;
            r_out_item.bucket_base   <= '0;
            r_out_item.hit_count     <= '0;
            r_out_item.percent       <= '0;
            r_out_item.entry_valid   <= 1'b0;
            r_out_item.last          <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_status.enable     = r_enable;
        o_status.total_zero = (r_total == 32'd0);
        o_status.mod_done   = IS_POW2 || r_quot_vld;
        o_status.scan_last  = (r_scan == LAST_IDX);
        o_status.best_zero  = (r_best_hits == 32'd0);
        o_status.div_done   = (r_k == 4'd0);
        o_status.last_entry = (r_rank == r_want) || (r_ncand != 2'd2);
        o_status.out_free   = !r_out_vld || i_out_ready;
    end

endmodule

`default_nettype wire

### src/pc_sample_histogram_top_n_core.sv
// Top level of the sampling profiler histogram with top-N dump.
// Depends on pshtn_pkg, pshtn_ctrl and pshtn_dpath.
//
// Opcode 0 counts a sample into bucket (pc >> granule_shift) mod BUCKETS when
// enable is set; opcode 2 clears all buckets and the total; opcode 1 dumps the
// best buckets, best first, lowest index on a tie, one result item per entry
// with last on the final one. Items are handled one at a time. A clear or an
// ignored item is finished at its accept; a sample goes on through the MOD and
// SWR states, and when BUCKETS is not a power of two the bucket index comes
// out of a reciprocal product computed in MOD. A dump with a zero total gives
// a single empty item. Otherwise each entry takes a scan of the hit memory
// through its single read port, the product by 100, a nine-step percent
// divider and the load of the result register, plus any time the result
// register waits on i_out_ready. Reset clears all buckets at once through
// per-bucket valid bits.
`timescale 1ns / 1ps
`default_nettype none

module pc_sample_histogram_top_n_core
    import pshtn_pkg::*;
#(
    parameter int unsigned BUCKETS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    pshtn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pshtn_dpath #(
        .BUCKETS (BUCKETS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### src/pshtn_checker.sv
// Port-level checks for the histogram top level, attached by bind.
// Depends on pshtn_pkg and pc_sample_histogram_top_n_core.
`timescale 1ns / 1ps
`default_nettype none

module pshtn_checker
    import pshtn_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // a result still waiting holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    // an empty result is the only, and so the final, item of its dump
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.entry_valid |->
            o_out_item.last && o_out_item.rank == 7'd0 &&
            o_out_item.hit_count == 32'd0 && o_out_item.percent == 7'd0)
        else $error("malformed empty result item");

    a_entry_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.entry_valid |->
            o_out_item.rank != 7'd0 && o_out_item.hit_count != 32'd0 &&
            o_out_item.percent <= 7'd100)
        else $error("malformed entry result item");

    // no new item is taken while a dump still has entries to give
    a_busy_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> !o_in_ready)
        else $error("input accepted in the middle of a dump");

endmodule

bind pc_sample_histogram_top_n_core pshtn_checker u_pshtn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

### verif/pc_sample_histogram_top_n_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for pc_sample_histogram_top_n_core: keeps a shadow copy
// of the bucket store, predicts every dump report and checks each result item.
// Depends on pshtn_pkg and the core RTL.

module pc_sample_histogram_top_n_core_test;
    import pshtn_pkg::*;

    localparam int BKT          = 64;
    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE       = 50;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class histogram_shadow;
        logic [31:0] hits [BKT];
        logic [31:0] bases [BKT];
        logic [31:0] total;
        logic        enable;
        logic [4:0]  shift;
        t_out_item   expected_entries [$];
        int          errors;

        function new();
            enable = 1'b0;
            shift  = GSHIFT_RST;
            errors = 0;
            clear_counts();
        endfunction

        function void clear_counts();
            foreach (hits[i]) begin
                hits[i]  = '0;
                bases[i] = '0;
            end
            total = '0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ENABLE) begin
                enable = data[0];
            end else begin
                shift = data[4:0];
            end
        endfunction

        function void add_sample(logic [31:0] pc);
            int unsigned b;
            b = (pc >> shift) % BKT;
            // a bucket at zero (fresh or wrapped) takes a new base
            if (hits[b] == '0) bases[b] = pc & ~((32'd1 << shift) - 32'd1);
            hits[b] += 32'd1;
            total   += 32'd1;
        endfunction

        function void predict_report(logic [7:0] count);
            t_out_item   report [$];
            t_out_item   e;
            bit          marked [BKT];
            int unsigned want;
            int unsigned best;
            logic [31:0] best_hits;
            logic [63:0] pct;
            want = count;
            if (want == 0 || want > BKT) want = DEFAULT_TOP;
            if (total != '0) begin
                for (int n = 0; n < want; n++) begin
                    best      = 0;
                    best_hits = '0;
                    // strict compare keeps the lowest index on a tie
                    for (int i = 0; i < BKT; i++) begin
                        if (!marked[i] && hits[i] > best_hits) begin
                            best_hits = hits[i];
                            best      = i;
                        end
                    end
                    if (best_hits == '0) break;
                    marked[best] = 1'b1;
                    pct = ({32'd0, best_hits} * 64'd100) / {32'd0, total};
                    if (pct > 64'd100) pct = 64'd100;
                    e               = '0;
                    e.total_samples = total;
                    e.rank          = 7'(n + 1);
                    e.bucket_base   = bases[best];
                    e.hit_count     = best_hits;
                    e.percent       = pct[6:0];
                    e.entry_valid   = 1'b1;
                    report.push_back(e);
                end
            end
            if (report.size() == 0) begin
                e               = '0;
                e.total_samples = total;
                report.push_back(e);
            end
            report[report.size() - 1].last = 1'b1;
            foreach (report[k]) expected_entries.push_back(report[k]);
        endfunction

        function void note_item(t_in_item it);
            case (it.opcode)
                OP_SAMPLE: if (enable) add_sample(it.pc_value);
                OP_DUMP:   predict_report(it.report_count);
                OP_CLEAR:  clear_counts();
                default:   ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_entry(t_out_item got);
            t_out_item want;
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected result item: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_entries.pop_front();
            check_field("total_samples", want.total_samples, got.total_samples);
            check_field("rank", want.rank, got.rank);
            check_field("bucket_base", want.bucket_base, got.bucket_base);
            check_field("hit_count", want.hit_count, got.hit_count);
            check_field("percent", want.percent, got.percent);
            check_field("entry_valid", want.entry_valid, got.entry_valid);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    histogram_shadow shadow;
    int burst_left  = 0;
    int cycle_count = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    pc_sample_histogram_top_n_core #(.BUCKETS(BKT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check on handshake, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) shadow.check_entry(o_out_item);
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (cycle_count[1:0] == 2'b11);
        endcase
    end

    function automatic t_in_item mk(logic [1:0] op, logic [31:0] pc, logic [7:0] cnt);
        t_in_item it;
        it.opcode       = op;
        it.pc_value     = pc;
        it.report_count = cnt;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        shadow.note_item(it);
        burst_left--;
    endtask

    // Drop valid, drain all expected results, then allow a slow sample to finish.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (shadow.expected_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic en, input logic [4:0] sh);
        logic [CFG_DATA_W-1:0] en_word;
        quiesce();
        en_word    = {4'($urandom), en};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ENABLE;
        i_cfg_data <= en_word;
        @(posedge i_clk);
        shadow.write_reg(CFG_ENABLE, en_word);
        i_cfg_idx  <= CFG_GSHIFT;
        i_cfg_data <= sh;
        @(posedge i_clk);
        shadow.write_reg(CFG_GSHIFT, sh);
        i_cfg_we   <= 1'b0;
    endtask

    // Samples cluster on a few hot granules of uneven weight, with some noise.
    task automatic run_phase(input logic en, input logic [4:0] sh, input int n_items);
        logic [31:0] hot [4];
        logic [31:0] mask;
        logic [7:0]  cnt;
        t_in_item    it;
        int          pick;
        int          r;
        set_config(en, sh);
        mask = (32'd1 << sh) - 32'd1;
        foreach (hot[k]) hot[k] = $urandom;
        if ($urandom_range(0, 1) == 1) send_item(mk(OP_CLEAR, $urandom, 8'($urandom)));
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            cnt  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6))
                                               : 8'($urandom_range(0, 255));
            if (n == n_items - 1 || pick < 12) begin
                it = mk(OP_DUMP, $urandom, cnt);
            end else if (pick < 17) begin
                it = mk(OP_CLEAR, $urandom, cnt);
            end else if (pick < 21) begin
                it = mk(OP_UNUSED, $urandom, cnt);
            end else if (pick < 36) begin
                it = mk(OP_SAMPLE, $urandom, cnt);
            end else begin
                r  = $urandom_range(0, 9);
                r  = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
                it = mk(OP_SAMPLE, hot[r] ^ ($urandom & mask), cnt);
            end
            send_item(it);
        end
    endtask

    initial begin
        shadow = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: counting off, so samples are dropped
        send_item(mk(OP_SAMPLE, 32'h0000_1234, 8'd0));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd0));
        send_item(mk(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF));

        // finest granule: ties between the first and last bucket
        set_config(1'b1, 5'd0);
        send_item(mk(OP_SAMPLE, 32'hFFFF_FFFF, 8'd0));
        send_item(mk(OP_SAMPLE, 32'h0000_0000, 8'd0));
        send_item(mk(OP_SAMPLE, 32'h0000_0040, 8'd0));
        send_item(mk(OP_SAMPLE, 32'h0000_007F, 8'd0));
        send_item(mk(OP_SAMPLE, 32'h0000_0015, 8'd0));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd1));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd64));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd65));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd255));
        send_item(mk(OP_CLEAR, 32'h0000_0000, 8'd0));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd3));

        // coarsest granule: only the top address bit picks the bucket
        set_config(1'b1, 5'd31);
        send_item(mk(OP_SAMPLE, 32'h8000_0000, 8'd0));
        send_item(mk(OP_SAMPLE, 32'h7FFF_FFFF, 8'd0));
        send_item(mk(OP_SAMPLE, 32'hDEAD_BEEF, 8'd0));
        send_item(mk(OP_DUMP, 32'h0000_0000, 8'd2));
        send_item(mk(OP_DUMP, 32'h5555_AAAA, 8'd0));

        run_phase(1'b1, 5'd24, 14);
        run_phase(1'b1, 5'd4, 14);
        run_phase(1'b0, 5'd7, 10);
        run_phase(1'b1, 5'd31, 12);
        run_phase(1'b1, 5'($urandom), 14);
        run_phase(1'b1, 5'd0, 14);

        quiesce();
        if (shadow.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
